// ===== rtl/core/bxavg_pkg.sv =====
package bxavg_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int LANES         = 4;
	localparam int CHAN_W        = 8;
	localparam int SUM_W         = LANES * CHAN_W;

	localparam int SCALE_W  = 4;
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 16;
	localparam int FMT_W    = 2;

	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_N     = 1 << (2 * SCALE_W);

	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_FORMAT = 2'd3
	} reg_idx_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_GRAY = 2'd0,
		FMT_RGB  = 2'd1,
		FMT_RGBA = 2'd2,
		FMT_ALT  = 2'd3
	} fmt_t;

	typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_N];

	typedef struct packed {
		logic               load;
		logic               div;
		logic               commit;
		logic               first;
		logic               emit;
		logic               row_end;
		logic               image_end;
		logic [LANES-1:0]   lane_en;
		logic [RECIP_W-1:0] recip;
	} ctl_t;

	// Ceiling reciprocal of bw*bh, indexed by {bw, bh}; exact floor division for bytes.
	function automatic recip_tab_t recip_table();
		recip_tab_t  t;
		int unsigned Den;
		for (int a = 0; a < (1 << SCALE_W); a++) begin
			for (int b = 0; b < (1 << SCALE_W); b++) begin
				Den = (a * b == 0) ? 1 : a * b;
				t[a * (1 << SCALE_W) + b] = RECIP_W'(((1 << RECIP_SHIFT) + Den - 1) / Den);
			end
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_TAB = recip_table();

endpackage

// ===== rtl/core/bxavg_ifs.sv =====
interface bxavg_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bxavg_pkg::CHAN_W-1:0] chan0;
	logic [bxavg_pkg::CHAN_W-1:0] chan1;
	logic [bxavg_pkg::CHAN_W-1:0] chan2;
	logic [bxavg_pkg::CHAN_W-1:0] chan3;

	modport source (output valid, output chan0, output chan1, output chan2, output chan3,
		input ready);
	modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
		output ready);
endinterface

interface bxavg_avg_if;
	logic                         valid;
	logic                         ready;
	logic [bxavg_pkg::CHAN_W-1:0] avg0;
	logic [bxavg_pkg::CHAN_W-1:0] avg1;
	logic [bxavg_pkg::CHAN_W-1:0] avg2;
	logic [bxavg_pkg::CHAN_W-1:0] avg3;
	logic                         row_end;
	logic                         image_end;

	modport source (output valid, output avg0, output avg1, output avg2, output avg3,
		output row_end, output image_end, input ready);
	modport sink (input valid, input avg0, input avg1, input avg2, input avg3,
		input row_end, input image_end, output ready);
endinterface

// ===== rtl/core/bxavg_lane.sv =====
module bxavg_lane (
	input  logic                         clk,
	input  bxavg_pkg::ctl_t              ctl,
	input  logic                         lane_en,
	input  logic [bxavg_pkg::CHAN_W-1:0] sample,
	input  logic [bxavg_pkg::CHAN_W-1:0] old,
	output logic [bxavg_pkg::CHAN_W-1:0] sum
);

	localparam int CW = bxavg_pkg::CHAN_W;
	localparam int PW = CW + bxavg_pkg::RECIP_W;
	localparam int SH = bxavg_pkg::RECIP_SHIFT;

	logic [CW-1:0] sample_q;
	logic [CW-1:0] quot_q;
	logic [PW-1:0] prod;
	logic [CW:0]   tot;

	assign prod = PW'(sample_q) * PW'(ctl.recip);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sample_q <= sample;
		end
		if (ctl.div) begin
			quot_q <= prod[SH+CW-1:SH];
		end
	end

	assign tot = (CW+1)'(old) + (CW+1)'(quot_q);

	always_comb begin
		if (!lane_en) begin
			sum = '0;
		end else if (tot[CW]) begin
			sum = '1;
		end else begin
			sum = tot[CW-1:0];
		end
	end

endmodule

// ===== rtl/core/bxavg_ctrl.sv =====
module bxavg_ctrl #(
	parameter  int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
	localparam int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bxavg_pkg::ADDR_W-1:0] paddr,
	input  logic [bxavg_pkg::DATA_W-1:0] pwdata,
	output logic [bxavg_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic                         out_free,
	output bxavg_pkg::ctl_t              ctl,
	output logic [CW-1:0]                rd_idx,
	output logic [CW-1:0]                wr_idx
);

	localparam int SW = bxavg_pkg::SCALE_W;
	localparam int WW = bxavg_pkg::WIDTH_W;
	localparam int HW = bxavg_pkg::HEIGHT_W;
	localparam int FW = bxavg_pkg::FMT_W;
	localparam int XW = ((CW > WW) ? CW : WW) + 1;
	localparam int NL = bxavg_pkg::LANES;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RECIP = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_ACC   = 4'b1000
	} state_t;

	state_t state_q;

	logic [SW-1:0] scale_q;
	logic [WW-1:0] src_width_q;
	logic [HW-1:0] src_height_q;
	logic [FW-1:0] fmt_q;

	logic [CW-1:0] src_col_q;
	logic [HW-1:0] src_row_q;
	logic [SW-1:0] col_in_q;
	logic [SW-1:0] row_in_q;
	logic [CW-1:0] out_col_q;

	logic [SW-1:0] bw_q;
	logic [SW-1:0] bh_q;
	logic          first_q;
	logic          emit_q;
	logic          row_end_q;
	logic          image_end_q;
	logic [CW-1:0] idx_q;
	logic [NL-1:0] lane_en_q;
	logic [bxavg_pkg::RECIP_W-1:0] recip_q;

	logic          wr_en;
	logic          load;
	logic          commit;
	logic [SW-1:0] sc;
	logic [WW-1:0] w_clamp;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          last_col;
	logic          last_row;
	logic          blk_col_end;
	logic          blk_row_end;
	logic [CW-1:0] col_start;
	logic [HW-1:0] row_start;
	logic [XW-1:0] rem_c;
	logic [HW-1:0] rem_r;
	logic [SW-1:0] bw;
	logic [SW-1:0] bh;
	logic [NL-1:0] lane_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= SW'(1);
			src_width_q  <= WW'(1);
			src_height_q <= HW'(1);
			fmt_q        <= bxavg_pkg::FMT_RGB;
		end else if (wr_en) begin
			case (bxavg_pkg::reg_idx_t'(paddr[bxavg_pkg::ADDR_W-1:2]))
				bxavg_pkg::REG_SCALE:  scale_q      <= pwdata[SW-1:0];
				bxavg_pkg::REG_WIDTH:  src_width_q  <= pwdata[WW-1:0];
				bxavg_pkg::REG_HEIGHT: src_height_q <= pwdata[HW-1:0];
				bxavg_pkg::REG_FORMAT: fmt_q        <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (bxavg_pkg::reg_idx_t'(paddr[bxavg_pkg::ADDR_W-1:2]))
			bxavg_pkg::REG_SCALE:  prdata = bxavg_pkg::DATA_W'(scale_q);
			bxavg_pkg::REG_WIDTH:  prdata = bxavg_pkg::DATA_W'(src_width_q);
			bxavg_pkg::REG_HEIGHT: prdata = bxavg_pkg::DATA_W'(src_height_q);
			bxavg_pkg::REG_FORMAT: prdata = bxavg_pkg::DATA_W'(fmt_q);
			default:               prdata = '0;
		endcase
	end

	assign sc      = (scale_q == '0) ? SW'(1) : scale_q;
	assign w_clamp = (32'(src_width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : src_width_q;
	assign w_eff   = (w_clamp == '0) ? WW'(1) : w_clamp;
	assign h_eff   = (src_height_q == '0) ? HW'(1) : src_height_q;

	assign last_col    = (XW'(src_col_q) + XW'(1)) >= XW'(w_eff);
	assign last_row    = ((HW+1)'(src_row_q) + (HW+1)'(1)) >= (HW+1)'(h_eff);
	assign blk_col_end = last_col || (((SW+1)'(col_in_q) + (SW+1)'(1)) >= (SW+1)'(sc));
	assign blk_row_end = last_row || (((SW+1)'(row_in_q) + (SW+1)'(1)) >= (SW+1)'(sc));

	assign col_start = src_col_q - CW'(col_in_q);
	assign row_start = src_row_q - HW'(row_in_q);
	assign rem_c = (XW'(w_eff) > XW'(col_start)) ? (XW'(w_eff) - XW'(col_start)) : XW'(1);
	assign rem_r = (h_eff > row_start) ? (h_eff - row_start) : HW'(1);
	assign bw    = (rem_c < XW'(sc)) ? rem_c[SW-1:0] : sc;
	assign bh    = (rem_r < HW'(sc)) ? rem_r[SW-1:0] : sc;

	always_comb begin
		case (bxavg_pkg::fmt_t'(fmt_q))
			bxavg_pkg::FMT_GRAY: lane_en = NL'(1);
			bxavg_pkg::FMT_RGB:  lane_en = NL'(7);
			default:             lane_en = '1;
		endcase
	end

	assign pix_ready = (state_q == ST_IDLE);
	assign load      = pix_valid && pix_ready;
	assign commit    = (state_q == ST_ACC) && (!emit_q || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (load) state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_ACC;
				ST_ACC:   if (commit) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			col_in_q  <= '0;
			row_in_q  <= '0;
			out_col_q <= '0;
		end else if (load) begin
			if (last_col) begin
				src_col_q <= '0;
				col_in_q  <= '0;
				out_col_q <= '0;
				if (last_row) begin
					src_row_q <= '0;
					row_in_q  <= '0;
				end else begin
					src_row_q <= src_row_q + HW'(1);
					row_in_q  <= blk_row_end ? '0 : row_in_q + SW'(1);
				end
			end else begin
				src_col_q <= src_col_q + CW'(1);
				if (blk_col_end) begin
					col_in_q  <= '0;
					out_col_q <= out_col_q + CW'(1);
				end else begin
					col_in_q <= col_in_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bw_q        <= bw;
			bh_q        <= bh;
			first_q     <= (col_in_q == '0) && (row_in_q == '0);
			emit_q      <= blk_col_end && blk_row_end;
			row_end_q   <= last_col;
			image_end_q <= last_col && last_row;
			idx_q       <= out_col_q;
			lane_en_q   <= lane_en;
		end
		if (state_q == ST_RECIP) begin
			recip_q <= bxavg_pkg::RECIP_TAB[{bw_q, bh_q}];
		end
	end

	assign rd_idx = out_col_q;
	assign wr_idx = idx_q;

	always_comb begin
		ctl.load      = load;
		ctl.div       = (state_q == ST_DIV);
		ctl.commit    = commit;
		ctl.first     = first_q;
		ctl.emit      = emit_q;
		ctl.row_end   = row_end_q;
		ctl.image_end = image_end_q;
		ctl.lane_en   = lane_en_q;
		ctl.recip     = recip_q;
	end

	a_word_reaches_acc: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ##3 (state_q == ST_ACC))
		else $error("accepted word did not reach accumulate step");

	a_col_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(col_in_q) <= src_col_q)
		else $error("column within block ahead of source column");

	a_row_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		HW'(row_in_q) <= src_row_q)
		else $error("row within block ahead of source row");

	a_block_size: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (bw_q != '0) && (bh_q != '0))
		else $error("zero block size");

endmodule

// ===== rtl/core/bxavg_merge.sv =====
module bxavg_merge #(
	parameter  int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
	localparam int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  bxavg_pkg::ctl_t                                 ctl,
	input  logic [CW-1:0]                                   rd_idx,
	input  logic [CW-1:0]                                   wr_idx,
	input  logic [bxavg_pkg::LANES-1:0][bxavg_pkg::CHAN_W-1:0] lane_sum,
	output logic [bxavg_pkg::LANES-1:0][bxavg_pkg::CHAN_W-1:0] lane_old,
	output logic                                            out_free,
	bxavg_avg_if.source                                     avg
);

	localparam int NL = bxavg_pkg::LANES;
	localparam int BW = bxavg_pkg::CHAN_W;

	logic [NL-1:0][BW-1:0] sums_mem [MAX_WIDTH];
	logic [NL-1:0][BW-1:0] rd_q;
	logic [NL-1:0][BW-1:0] out_q;
	logic                  out_valid_q;
	logic                  row_end_q;
	logic                  image_end_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_q <= sums_mem[rd_idx];
		end
		if (ctl.commit) begin
			sums_mem[wr_idx] <= lane_sum;
		end
	end

	assign lane_old = ctl.first ? '0 : rd_q;
	assign out_free = !out_valid_q || avg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (avg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && ctl.emit) begin
			out_q       <= lane_sum;
			row_end_q   <= ctl.row_end;
			image_end_q <= ctl.image_end;
		end
	end

	assign avg.valid     = out_valid_q;
	assign avg.avg0      = out_q[0];
	assign avg.avg1      = out_q[1];
	assign avg.avg2      = out_q[2];
	assign avg.avg3      = out_q[3];
	assign avg.row_end   = row_end_q;
	assign avg.image_end = image_end_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && ctl.emit) |-> out_free)
		else $error("result register overwritten while held");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !ctl.commit)
		else $error("sum read and write in the same cycle");

endmodule

// ===== rtl/core/box_average_downscaler.sv =====
// channel  dir  role                        handshake
// pix      in   source pixel, chan0..chan3  valid/ready, raster order
// avg      out  block average, end flags    valid/ready, one word per block
// apb      in   scale, width, height, fmt   psel/penable, pready tied high
//
// Each pixel passes in turn through accept with sum read, reciprocal lookup,
// lane multiply, then accumulate with sum write-back and result load.
// Due to the column-sum read-modify-write, a new pixel is taken only after accumulate.
// A block-ending accumulate step holds while a finished block is still unread.
// Reset clears position counters, the step sequencer and result valid;
// the column sums need no clearing since each block starts its own sum.
module box_average_downscaler #(
	parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bxavg_pkg::ADDR_W-1:0] paddr,
	input  logic [bxavg_pkg::DATA_W-1:0] pwdata,
	output logic [bxavg_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	bxavg_pix_if.sink                    pix,
	bxavg_avg_if.source                  avg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int NL = bxavg_pkg::LANES;
	localparam int BW = bxavg_pkg::CHAN_W;

	bxavg_pkg::ctl_t       ctl;
	logic [CW-1:0]         rd_idx;
	logic [CW-1:0]         wr_idx;
	logic                  out_free;
	logic [NL-1:0][BW-1:0] pix_chan;
	logic [NL-1:0][BW-1:0] lane_old;
	logic [NL-1:0][BW-1:0] lane_sum;

	assign pix_chan = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};

	bxavg_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.out_free  (out_free),
		.ctl       (ctl),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx)
	);

	for (genvar i = 0; i < NL; i++) begin : g_lane
		bxavg_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.lane_en (ctl.lane_en[i]),
			.sample  (pix_chan[i]),
			.old     (lane_old[i]),
			.sum     (lane_sum[i])
		);
	end

	bxavg_merge #(.MAX_WIDTH(MAX_WIDTH)) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.lane_sum (lane_sum),
		.lane_old (lane_old),
		.out_free (out_free),
		.avg      (avg)
	);

endmodule
